// ----- hdl/dsd_pkg.sv -----
// ---------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the disparity shift to depth converter.
// ---------------------------------------------------------------------------
package dsd_pkg;

   // field widths
   localparam int SHIFT_W        = 11;
   localparam int DEPTH_W        = 16;
   localparam int PIXEL_SIZE_W   = 16;
   localparam int PLANE_DIST_W   = 12;
   localparam int EMIT_DIST_W    = 20;
   localparam int SHIFT_OFFSET_W = 12;
   localparam int COEFF_W        = 4;
   localparam int SCALE_W        = 8;
   localparam int CUTOFF_W       = 16;
   localparam int CSR_DATA_W     = 20;

   // default upper limit of a usable shift
   localparam int MAX_SHIFT_DEFAULT = 2047;

   // register reset values
   localparam logic [PIXEL_SIZE_W-1:0]   PIXEL_SIZE_RST   = 16'd6832;
   localparam logic [PLANE_DIST_W-1:0]   PLANE_DIST_RST   = 12'd120;
   localparam logic [EMIT_DIST_W-1:0]    EMIT_DIST_RST    = 20'd491520;
   localparam logic [SHIFT_OFFSET_W-1:0] SHIFT_OFFSET_RST = 12'd800;
   localparam logic [COEFF_W-1:0]        COEFF_RST        = 4'd4;
   localparam logic [SCALE_W-1:0]        SCALE_RST        = 8'd10;
   localparam logic [CUTOFF_W-1:0]       MIN_CUTOFF_RST   = 16'd0;
   localparam logic [CUTOFF_W-1:0]       MAX_CUTOFF_RST   = 16'd10000;

   // 0.375 in Q16
   localparam logic [14:0] REF_BIAS = 15'd24576;

   // register map
   typedef enum logic [2:0] {
      CSR_PIXEL_SIZE,
      CSR_PLANE_DISTANCE,
      CSR_EMITTER_DISTANCE,
      CSR_SHIFT_OFFSET,
      CSR_PARAM_COEFF,
      CSR_SHIFT_SCALE,
      CSR_MIN_CUTOFF,
      CSR_MAX_CUTOFF
   } csr_index_type;

   // input item
   typedef struct packed {
      logic [SHIFT_W-1:0] shift_value;
      logic               frame_end;
   } req_type;

   // result item
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               last;
   } rsp_type;

endpackage

// ----- hdl/disparity_shift_to_depth_core.sv -----
// ---------------------------------------------------------------------------
// disparity_shift_to_depth_core
// Per-pixel conversion of a raw disparity shift into a depth value.
// ---------------------------------------------------------------------------
// One pixel is taken in every clock cycle and its depth comes out on rsp_item
// with rsp_strobe, having passed the two dividers in the pipeline: six stages
// that divide the shift difference by param_coeff five quotient bits at a
// time, and sixteen stages that form the depth quotient one bit per stage.
// Results cannot be held off, so the pipeline never stalls; busy is high only
// while reset is held. Registers may be written only while no pixel is in
// flight; the scale*distance*baseline product is registered in scale_dist_ff
// and then numer_ff after a write.
module disparity_shift_to_depth_core #(
   parameter int MAX_SHIFT = dsd_pkg::MAX_SHIFT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input
   input  logic                                  start,
   output logic                                  busy,
   input  dsd_pkg::req_type                      req_item,
   // depth output
   output logic                                  rsp_strobe,
   output dsd_pkg::rsp_type                      rsp_item,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  dsd_pkg::csr_index_type                csr_index,
   input  logic [dsd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import dsd_pkg::*;

   localparam int MAG_W       = 30;              // magnitude of the ref numerator
   localparam int CDIV_BITS   = 5;               // quotient bits per coeff stage
   localparam int CDIV_STAGES = MAG_W / CDIV_BITS;
   localparam int PROD_W      = MAG_W + PIXEL_SIZE_W;
   localparam int METRIC_W    = PROD_W - 15;     // magnitude after the Q16 drop
   localparam int DEN_W       = 32;              // positive denominator
   localparam int N_W         = SCALE_W + PLANE_DIST_W + EMIT_DIST_W;
   localparam int CMP_W       = DEN_W + CUTOFF_W;
   localparam int QUOT_W      = DEPTH_W;
   localparam int PIPE_LAT    = CDIV_STAGES + QUOT_W + 8;

   localparam logic [SHIFT_W:0] SHIFT_LIMIT = (SHIFT_W+1)'(MAX_SHIFT);

   typedef struct packed {
      logic               valid;
      logic [SHIFT_W-1:0] shift;
      logic               last;
   } in_stage_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic               kill;
      logic               neg;
      logic [COEFF_W-1:0] rem;
      logic [MAG_W-1:0]   word;
   } cdiv_stage_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              kill;
      logic              neg;
      logic [PROD_W-1:0] prod;
   } mul_stage_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic                kill;
      logic                neg;
      logic [METRIC_W-1:0] mag;
   } met_stage_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic             kill;
      logic [DEN_W-1:0] den;
   } den_stage_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic             kill;
      logic [DEN_W-1:0] den;
      logic [CMP_W-1:0] lo_bound;
      logic [CMP_W-1:0] hi_bound;
   } cut_stage_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              keep;
      logic [DEN_W-1:0]  den;
      logic [N_W-1:0]    rem;
      logic [QUOT_W-1:0] quot;
   } qdiv_stage_type;

   // configuration registers
   logic [PIXEL_SIZE_W-1:0]   pixel_size_ff;
   logic [PLANE_DIST_W-1:0]   plane_distance_ff;
   logic [EMIT_DIST_W-1:0]    emitter_distance_ff;
   logic [SHIFT_OFFSET_W-1:0] shift_offset_ff;
   logic [COEFF_W-1:0]        param_coeff_ff;
   logic [SCALE_W-1:0]        shift_scale_ff;
   logic [CUTOFF_W-1:0]       min_cutoff_ff;
   logic [CUTOFF_W-1:0]       max_cutoff_ff;

   // derived numerator scale*dist*emit
   logic [SCALE_W+PLANE_DIST_W-1:0] scale_dist_ff;
   logic [N_W-1:0]                  numer_ff;

   in_stage_type   in_ff, in_in;
   cdiv_stage_type cd_ff [CDIV_STAGES+1];
   cdiv_stage_type cd_in [CDIV_STAGES+1];
   mul_stage_type  mul_ff, mul_in;
   met_stage_type  met_ff, met_in;
   den_stage_type  den_ff, den_in;
   cut_stage_type  cut_ff, cut_in;
   qdiv_stage_type qd_ff [QUOT_W+1];
   qdiv_stage_type qd_in [QUOT_W+1];
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff;

   assign busy      = reset;
   assign csr_ready = ~reset;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_size_ff       <= PIXEL_SIZE_RST;
         plane_distance_ff   <= PLANE_DIST_RST;
         emitter_distance_ff <= EMIT_DIST_RST;
         shift_offset_ff     <= SHIFT_OFFSET_RST;
         param_coeff_ff      <= COEFF_RST;
         shift_scale_ff      <= SCALE_RST;
         min_cutoff_ff       <= MIN_CUTOFF_RST;
         max_cutoff_ff       <= MAX_CUTOFF_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_SIZE:       pixel_size_ff       <= csr_wdata[PIXEL_SIZE_W-1:0];
            CSR_PLANE_DISTANCE:   plane_distance_ff   <= csr_wdata[PLANE_DIST_W-1:0];
            CSR_EMITTER_DISTANCE: emitter_distance_ff <= csr_wdata[EMIT_DIST_W-1:0];
            CSR_SHIFT_OFFSET:     shift_offset_ff     <= csr_wdata[SHIFT_OFFSET_W-1:0];
            CSR_PARAM_COEFF:      param_coeff_ff      <= csr_wdata[COEFF_W-1:0];
            CSR_SHIFT_SCALE:      shift_scale_ff      <= csr_wdata[SCALE_W-1:0];
            CSR_MIN_CUTOFF:       min_cutoff_ff       <= csr_wdata[CUTOFF_W-1:0];
            CSR_MAX_CUTOFF:       max_cutoff_ff       <= csr_wdata[CUTOFF_W-1:0];
            default: ;
         endcase
      end
   end

   // numerator product, two multiplies in series
   always_ff @(posedge clock) begin
      scale_dist_ff <= {{PLANE_DIST_W{1'b0}}, shift_scale_ff}
                     * {{SCALE_W{1'b0}}, plane_distance_ff};
      numer_ff      <= {{EMIT_DIST_W{1'b0}}, scale_dist_ff}
                     * {{(SCALE_W+PLANE_DIST_W){1'b0}}, emitter_distance_ff};
   end

   // input capture
   always_comb begin
      in_in.valid = start && !busy;
      in_in.shift = req_item.shift_value;
      in_in.last  = req_item.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) in_ff <= '0;
      else       in_ff <= in_in;
   end

   // ref numerator: diff*65536 - 0.375*coeff in Q16, split into sign and magnitude
   always_comb begin
      logic [SHIFT_W+1:0] diff;
      logic [18:0]        bias;
      logic [30:0]        num;
      logic [30:0]        mag;
      diff = {2'b00, in_ff.shift} - {1'b0, shift_offset_ff};
      bias = {4'b0000, REF_BIAS} * {15'd0, param_coeff_ff};
      num  = {{2{diff[SHIFT_W+1]}}, diff, 16'h0000} - {12'd0, bias};
      mag  = num[30] ? (~num + 31'd1) : num;
      cd_in[0].valid = in_ff.valid;
      cd_in[0].last  = in_ff.last;
      cd_in[0].kill  = (in_ff.shift == '0) || ({1'b0, in_ff.shift} >= SHIFT_LIMIT)
                       || (param_coeff_ff == '0);
      cd_in[0].neg   = num[30];
      cd_in[0].rem   = '0;
      cd_in[0].word  = mag[MAG_W-1:0];
   end

   // restoring division by param_coeff, a few quotient bits per stage
   for (genvar s = 0; s < CDIV_STAGES; s++) begin : g_cdiv
      always_comb begin
         logic [COEFF_W:0]   trial;
         logic [COEFF_W-1:0] rem;
         logic [MAG_W-1:0]   word;
         rem  = cd_ff[s].rem;
         word = cd_ff[s].word;
         for (int k = 0; k < CDIV_BITS; k++) begin
            trial = {rem, word[MAG_W-1]};
            word  = {word[MAG_W-2:0], 1'b0};
            if (trial >= {1'b0, param_coeff_ff}) begin
               trial   = trial - {1'b0, param_coeff_ff};
               word[0] = 1'b1;
            end
            rem = trial[COEFF_W-1:0];
         end
         cd_in[s+1]      = cd_ff[s];
         cd_in[s+1].rem  = rem;
         cd_in[s+1].word = word;
      end
   end

   for (genvar s = 0; s <= CDIV_STAGES; s++) begin : g_cd_reg
      always_ff @(posedge clock) begin
         if (reset) cd_ff[s] <= '0;
         else       cd_ff[s] <= cd_in[s];
      end
   end

   // |ref| times pixel size
   always_comb begin
      mul_in.valid = cd_ff[CDIV_STAGES].valid;
      mul_in.last  = cd_ff[CDIV_STAGES].last;
      mul_in.kill  = cd_ff[CDIV_STAGES].kill;
      mul_in.neg   = cd_ff[CDIV_STAGES].neg;
      mul_in.prod  = {{PIXEL_SIZE_W{1'b0}}, cd_ff[CDIV_STAGES].word}
                   * {{MAG_W{1'b0}}, pixel_size_ff};
   end

   // drop the Q16 fraction, rounding toward minus infinity
   always_comb begin
      logic [PROD_W:0] up;
      up = {1'b0, mul_ff.prod} + (PROD_W+1)'(16'hFFFF);
      met_in.valid = mul_ff.valid;
      met_in.last  = mul_ff.last;
      met_in.kill  = mul_ff.kill;
      met_in.neg   = mul_ff.neg;
      met_in.mag   = mul_ff.neg ? up[PROD_W:16] : {1'b0, mul_ff.prod[PROD_W-1:16]};
   end

   // denominator emit - metric, rejected when not positive
   always_comb begin
      logic [METRIC_W:0]  metric;
      logic [DEN_W:0]     den;
      metric = met_ff.neg ? (~{1'b0, met_ff.mag} + 1'b1) : {1'b0, met_ff.mag};
      den    = {{(DEN_W+1-EMIT_DIST_W){1'b0}}, emitter_distance_ff}
             - {{(DEN_W-METRIC_W){metric[METRIC_W]}}, metric};
      den_in.valid = met_ff.valid;
      den_in.last  = met_ff.last;
      den_in.kill  = met_ff.kill || den[DEN_W] || (den == '0);
      den_in.den   = den[DEN_W-1:0];
   end

   // cutoffs scaled by the denominator
   always_comb begin
      cut_in.valid    = den_ff.valid;
      cut_in.last     = den_ff.last;
      cut_in.kill     = den_ff.kill;
      cut_in.den      = den_ff.den;
      cut_in.lo_bound = {{DEN_W{1'b0}}, min_cutoff_ff} * {{CUTOFF_W{1'b0}}, den_ff.den};
      cut_in.hi_bound = {{DEN_W{1'b0}}, max_cutoff_ff} * {{CUTOFF_W{1'b0}}, den_ff.den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= '0;
         met_ff <= '0;
         den_ff <= '0;
         cut_ff <= '0;
      end else begin
         mul_ff <= mul_in;
         met_ff <= met_in;
         den_ff <= den_in;
         cut_ff <= cut_in;
      end
   end

   // exact range check; a kept depth has a quotient below 2^16
   always_comb begin
      logic [CMP_W-1:0] n_ext;
      n_ext = {{(CMP_W-N_W){1'b0}}, numer_ff};
      qd_in[0].valid = cut_ff.valid;
      qd_in[0].last  = cut_ff.last;
      qd_in[0].keep  = !cut_ff.kill && (n_ext > cut_ff.lo_bound) && (n_ext < cut_ff.hi_bound);
      qd_in[0].den   = cut_ff.den;
      qd_in[0].rem   = numer_ff;
      qd_in[0].quot  = '0;
   end

   // depth quotient, one bit per stage from the top
   for (genvar b = 0; b < QUOT_W; b++) begin : g_qdiv
      localparam int SH = QUOT_W - 1 - b;
      always_comb begin
         logic [CMP_W-1:0] dsh;
         logic [CMP_W-1:0] r_ext;
         dsh   = {{CUTOFF_W{1'b0}}, qd_ff[b].den} << SH;
         r_ext = {{(CMP_W-N_W){1'b0}}, qd_ff[b].rem};
         qd_in[b+1] = qd_ff[b];
         if (r_ext >= dsh) begin
            qd_in[b+1].rem      = N_W'(r_ext - dsh);
            qd_in[b+1].quot[SH] = 1'b1;
         end
      end
   end

   for (genvar b = 0; b <= QUOT_W; b++) begin : g_qd_reg
      always_ff @(posedge clock) begin
         if (reset) qd_ff[b] <= '0;
         else       qd_ff[b] <= qd_in[b];
      end
   end

   // output register
   always_comb begin
      rsp_in.depth = qd_ff[QUOT_W].keep ? qd_ff[QUOT_W].quot : '0;
      rsp_in.last  = qd_ff[QUOT_W].last;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= qd_ff[QUOT_W].valid;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // every accepted item comes out after the fixed latency
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_strobe)
      else $error("accepted item did not come out after pipeline latency");

   // no result without an item accepted at the matching time
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LAT))
      else $error("result without a matching accepted item");

   // frame end marker travels with its pixel
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.last == $past(req_item.frame_end, PIPE_LAT)))
      else $error("last flag does not match its pixel");

   // a zero shift always yields a zero depth
   a_zero_shift: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(start && !busy && (req_item.shift_value == '0), PIPE_LAT))
      |-> (rsp_item.depth == '0))
      else $error("zero shift produced a nonzero depth");

endmodule

// ----- sim/tb_disparity_shift_to_depth_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_disparity_shift_to_depth_core
// Self-checking bench for the disparity shift to depth converter. A clocked
// driver streams pixels from a queue with random gaps. A clocked monitor
// checks every depth result against a predictor that rebuilds the
// fixed-point triangulation from a local copy of the registers. Phases run
// on an empty pipeline: reset defaults, narrow cutoff window, both extremes,
// crossed cutoffs, a zero divisor, over-wide writes and random settings.
// ---------------------------------------------------------------------------
module tb_disparity_shift_to_depth_core;
   import dsd_pkg::*;

   localparam int     MAX_SHIFT   = MAX_SHIFT_DEFAULT;
   localparam longint BIAS_Q16    = 24576;   // 0.375 in Q16
   localparam int     PIPE_CYCLES = 30;

   // pixel waiting to be driven, with the idle cycles that go ahead of it
   typedef struct {
      req_type item;
      int      gap;
   } pixel_slot_type;

   // depth expected back, with its shift kept for reporting
   typedef struct {
      rsp_type             result;
      logic [SHIFT_W-1:0]  shift;
   } depth_due_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic                  busy;
   req_type               req_item   = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_item;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index  = CSR_PIXEL_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // local copy of the register file
   logic [PIXEL_SIZE_W-1:0]   cfg_pixel_size = PIXEL_SIZE_RST;
   logic [PLANE_DIST_W-1:0]   cfg_plane_dist = PLANE_DIST_RST;
   logic [EMIT_DIST_W-1:0]    cfg_emit_dist  = EMIT_DIST_RST;
   logic [SHIFT_OFFSET_W-1:0] cfg_offset     = SHIFT_OFFSET_RST;
   logic [COEFF_W-1:0]        cfg_coeff      = COEFF_RST;
   logic [SCALE_W-1:0]        cfg_scale      = SCALE_RST;
   logic [CUTOFF_W-1:0]       cfg_min_cutoff = MIN_CUTOFF_RST;
   logic [CUTOFF_W-1:0]       cfg_max_cutoff = MAX_CUTOFF_RST;

   pixel_slot_type pixel_queue[$];
   depth_due_type  depth_due_q[$];

   int error_count    = 0;
   int pixels_sent    = 0;
   int depths_checked = 0;
   int depths_kept    = 0;
   int csr_writes     = 0;
   int settings_used  = 1;

   disparity_shift_to_depth_core #(
      .MAX_SHIFT(MAX_SHIFT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // depth of one shift under the current register copy
   function automatic logic [DEPTH_W-1:0] shift_to_depth(logic [SHIFT_W-1:0] shift);
      longint diff, num, ref_q16, prod, metric, den, numer;
      if (shift == 0 || int'(shift) >= MAX_SHIFT || cfg_coeff == 0)
         return '0;
      diff    = longint'(shift) - longint'(cfg_offset);
      num     = diff * 65536 - BIAS_Q16 * longint'(cfg_coeff);
      ref_q16 = num / longint'(cfg_coeff);          // truncates toward zero
      prod    = ref_q16 * longint'(cfg_pixel_size);
      metric  = prod >>> 16;                         // floor division by 2^16
      den     = longint'(cfg_emit_dist) - metric;
      if (den <= 0)
         return '0;
      numer = longint'(cfg_scale) * longint'(cfg_plane_dist) * longint'(cfg_emit_dist);
      // exact quotient must lie strictly between the cutoffs
      if (!(numer > longint'(cfg_min_cutoff) * den))
         return '0;
      if (!(numer < longint'(cfg_max_cutoff) * den))
         return '0;
      return DEPTH_W'(numer / den);
   endfunction

   // pixel driver: predicts each accepted item, then presents the next one
   always @(posedge clock) begin : pixel_driver
      depth_due_type due;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            due.result.depth = shift_to_depth(req_item.shift_value);
            due.result.last  = req_item.frame_end;
            due.shift        = req_item.shift_value;
            depth_due_q.push_back(due);
            pixels_sent++;
         end
         if (!(start && busy)) begin
            if (pixel_queue.size() == 0) begin
               start <= 1'b0;
            end else if (pixel_queue[0].gap > 0) begin
               pixel_queue[0].gap = pixel_queue[0].gap - 1;
               start <= 1'b0;
            end else begin
               req_item <= pixel_queue[0].item;
               start    <= 1'b1;
               void'(pixel_queue.pop_front());
            end
         end
      end
   end

   // depth monitor: every strobe is checked against the oldest prediction
   always @(posedge clock) begin : depth_monitor
      depth_due_type due;
      if (!reset && rsp_strobe === 1'b1) begin
         if (depth_due_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual depth %0d last %0b",
                     $time, rsp_item.depth, rsp_item.last);
         end else begin
            due = depth_due_q.pop_front();
            depths_checked++;
            if (due.result.depth != 0)
               depths_kept++;
            if (rsp_item.depth !== due.result.depth) begin
               error_count++;
               $display("%0t: depth mismatch at shift %0d, expected %0d, actual %0d",
                        $time, due.shift, due.result.depth, rsp_item.depth);
            end
            if (rsp_item.last !== due.result.last) begin
               error_count++;
               $display("%0t: last mismatch at shift %0d, expected %0b, actual %0b",
                        $time, due.shift, due.result.last, rsp_item.last);
            end
         end
      end
   end

   // idle cycles ahead of an item: mostly none, some short, a few long
   function automatic int pick_gap(bit idle_on);
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // shifts cluster around the offset where depths are kept
   function automatic logic [SHIFT_W-1:0] pick_shift();
      int r, lo, hi;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SHIFT_W'(1);
            2:       return SHIFT_W'(MAX_SHIFT - 1);
            default: return SHIFT_W'(MAX_SHIFT);
         endcase
      end
      if (r < 38)
         return SHIFT_W'($urandom_range(0, 2047));
      lo = int'(cfg_offset) - 400;
      hi = int'(cfg_offset) + 400;
      if (lo < 1)
         lo = 1;
      if (hi > 2046)
         hi = 2046;
      if (lo > hi)
         return SHIFT_W'($urandom_range(0, 2047));
      return SHIFT_W'($urandom_range(lo, hi));
   endfunction

   // first item of a phase waits so the register-derived product can settle
   task automatic queue_pixel(logic [SHIFT_W-1:0] shift, logic last, int gap);
      pixel_slot_type slot;
      slot.item.shift_value = shift;
      slot.item.frame_end   = last;
      slot.gap              = (pixel_queue.size() == 0 && gap < 3) ? 3 : gap;
      pixel_queue.push_back(slot);
   endtask

   task automatic queue_random_pixels(int count, bit idle_on);
      for (int i = 0; i < count; i++)
         queue_pixel(pick_shift(), $urandom_range(0, 7) == 0, pick_gap(idle_on));
   endtask

   // wait until every queued item is in and every depth has come back
   task automatic drain_pipeline();
      while (pixel_queue.size() != 0 || start || depth_due_q.size() != 0)
         @(posedge clock);
   endtask

   // one register write, with a random hold-off ahead of it
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      repeat ($urandom_range(0, 3)) @(posedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_PIXEL_SIZE:       cfg_pixel_size = data[PIXEL_SIZE_W-1:0];
         CSR_PLANE_DISTANCE:   cfg_plane_dist = data[PLANE_DIST_W-1:0];
         CSR_EMITTER_DISTANCE: cfg_emit_dist  = data[EMIT_DIST_W-1:0];
         CSR_SHIFT_OFFSET:     cfg_offset     = data[SHIFT_OFFSET_W-1:0];
         CSR_PARAM_COEFF:      cfg_coeff      = data[COEFF_W-1:0];
         CSR_SHIFT_SCALE:      cfg_scale      = data[SCALE_W-1:0];
         CSR_MIN_CUTOFF:       cfg_min_cutoff = data[CUTOFF_W-1:0];
         CSR_MAX_CUTOFF:       cfg_max_cutoff = data[CUTOFF_W-1:0];
         default: ;
      endcase
   endtask

   // sometimes fill the bits above the register width with junk
   function automatic logic [CSR_DATA_W-1:0] junk_above(logic [CSR_DATA_W-1:0] value,
                                                       int width);
      logic [CSR_DATA_W-1:0] upper;
      upper = {CSR_DATA_W{1'b1}} << width;
      if (width >= CSR_DATA_W || $urandom_range(0, 4) != 0)
         return value;
      return (value & ~upper) | (CSR_DATA_W'($urandom) & upper);
   endfunction

   task automatic load_settings(int psize, int plane_dist, int emit, int offset,
                                int coeff, int scale, int min_c, int max_c);
      write_csr(CSR_PIXEL_SIZE,       junk_above(CSR_DATA_W'(psize),      PIXEL_SIZE_W));
      write_csr(CSR_PLANE_DISTANCE,   junk_above(CSR_DATA_W'(plane_dist), PLANE_DIST_W));
      write_csr(CSR_EMITTER_DISTANCE, junk_above(CSR_DATA_W'(emit),       EMIT_DIST_W));
      write_csr(CSR_SHIFT_OFFSET,     junk_above(CSR_DATA_W'(offset),     SHIFT_OFFSET_W));
      write_csr(CSR_PARAM_COEFF,      junk_above(CSR_DATA_W'(coeff),      COEFF_W));
      write_csr(CSR_SHIFT_SCALE,      junk_above(CSR_DATA_W'(scale),      SCALE_W));
      write_csr(CSR_MIN_CUTOFF,       junk_above(CSR_DATA_W'(min_c),      CUTOFF_W));
      write_csr(CSR_MAX_CUTOFF,       junk_above(CSR_DATA_W'(max_c),      CUTOFF_W));
      settings_used++;
   endtask

   // random setting, mostly one where scale*distance keeps depths in range
   task automatic random_settings();
      int plane_dist, scale_top, min_c, max_c;
      plane_dist = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(20, 800);
      scale_top = (plane_dist == 0) ? 255 : 60000 / plane_dist;
      if (scale_top > 255)
         scale_top = 255;
      if (scale_top < 1)
         scale_top = 1;
      min_c = $urandom_range(0, 1500);
      max_c = $urandom_range(min_c, 65535);
      if ($urandom_range(0, 3) == 0) begin
         min_c = 0;
         max_c = 65535;
      end
      load_settings(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(1000, 30000),
                    plane_dist,
                    $urandom_range(65536, 1048575),
                    $urandom_range(100, 1900),
                    $urandom_range(1, 15),
                    $urandom_range(1, scale_top),
                    min_c, max_c);
   endtask

   // stimulus sequence
   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);

      // reset defaults: zero shift, top of range, shift limit, bit patterns,
      // the offset itself, the cutoff edge and a negative denominator
      queue_pixel(SHIFT_W'(0), 1'b0, 0);
      queue_pixel(SHIFT_W'(1), 1'b1, 0);
      queue_pixel(SHIFT_W'(MAX_SHIFT - 1), 1'b0, 0);
      queue_pixel(SHIFT_W'(MAX_SHIFT), 1'b1, 1);
      queue_pixel(11'h7ff, 1'b0, 0);
      queue_pixel(11'h555, 1'b1, 0);
      queue_pixel(11'h2aa, 1'b0, 2);
      queue_pixel(SHIFT_W'(100), 1'b0, 0);
      queue_pixel(SHIFT_W'(799), 1'b0, 0);
      queue_pixel(SHIFT_W'(800), 1'b1, 0);
      queue_pixel(SHIFT_W'(801), 1'b0, 0);
      queue_pixel(SHIFT_W'(1050), 1'b0, 0);
      queue_pixel(SHIFT_W'(1080), 1'b0, 0);
      queue_pixel(SHIFT_W'(1088), 1'b0, 0);
      queue_pixel(SHIFT_W'(1089), 1'b0, 0);
      queue_pixel(SHIFT_W'(1090), 1'b1, 0);
      queue_pixel(SHIFT_W'(1500), 1'b0, 0);
      queue_pixel(SHIFT_W'(2000), 1'b1, 0);
      drain_pipeline();
      queue_random_pixels(150, 1'b1);
      drain_pipeline();

      // narrow cutoff window around the default depths
      write_csr(CSR_MIN_CUTOFF, 20'd1150);
      write_csr(CSR_MAX_CUTOFF, 20'd1250);
      settings_used++;
      queue_pixel(SHIFT_W'(400), 1'b0, 0);
      queue_pixel(SHIFT_W'(700), 1'b0, 0);
      queue_pixel(SHIFT_W'(780), 1'b1, 0);
      queue_pixel(SHIFT_W'(800), 1'b0, 0);
      queue_pixel(SHIFT_W'(850), 1'b0, 0);
      queue_pixel(SHIFT_W'(950), 1'b1, 0);
      drain_pipeline();

      // lowest register values
      load_settings(0, 0, 0, 0, 1, 1, 0, 65535);
      queue_random_pixels(40, 1'b1);
      drain_pipeline();

      // highest register values, back to back items
      load_settings(65535, 4095, 1048575, 4095, 15, 255, 0, 65535);
      queue_random_pixels(40, 1'b0);
      drain_pipeline();

      // cutoffs crossed: nothing can be kept
      load_settings(6832, 120, 491520, 800, 4, 10, 65535, 0);
      queue_random_pixels(30, 1'b1);
      drain_pipeline();

      // zero divisor through a truncated write, others over-wide
      random_settings();
      write_csr(CSR_PARAM_COEFF, 20'hffff0);
      queue_random_pixels(40, 1'b1);
      drain_pipeline();

      // random settings, some phases without idling
      for (int k = 0; k < 7; k++) begin
         random_settings();
         queue_random_pixels(175, k % 3 != 0);
         drain_pipeline();
      end

      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (depth_due_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d depth results never arrived", $time, depth_due_q.size());
      end
      $display("covered %0d pixels, %0d results checked, %0d with a kept depth",
               pixels_sent, depths_checked, depths_kept);
      $display("over %0d register settings with %0d register writes",
               settings_used, csr_writes);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #10000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- disparity_shift_to_depth_core.f -----
hdl/dsd_pkg.sv
hdl/disparity_shift_to_depth_core.sv
sim/tb_disparity_shift_to_depth_core.sv
